### rtl/lpe_pkg.sv
// Shared types and constants for the linear potential energy dot-product block.
package lpe_pkg;

    // Request operation codes
    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_DESCRIPTORS_IN_USE = 1'b0,
        REG_ENERGY_ENABLE      = 1'b1
    } t_reg;

    localparam int CFG_DATA_W = 7;
    localparam logic [6:0] DESC_RESET = 7'd64;

    // Output queue sizing
    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = 3;
    localparam int CNT_W      = 4;

    // Per-request control that travels down the pipeline
    typedef struct packed {
        logic res;    // request produces a result
        logic clr;    // clear total, accumulator and flag
        logic use_e;  // sample contributes to the energy
        logic first;  // descriptor index zero, bias goes in first
        logic done;   // last descriptor of the atom
    } t_ctl;

    // One result as it sits in the output queue
    typedef struct packed {
        logic [31:0] beta;
        logic [47:0] atom_energy;
        logic [47:0] total_energy;
        logic        atom_done;
        logic        overflow;
    } t_result;

endpackage

### rtl/lpe_coef_mem.sv
// Coefficient store: one write port and two registered read ports.
module lpe_coef_mem import lpe_pkg::*; #(
    parameter int DEPTH = 520,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [31:0]   i_wdata,
    input  logic [AW-1:0] i_raddr_w,
    input  logic [AW-1:0] i_raddr_b,
    output logic [31:0]   o_weight,
    output logic [31:0]   o_bias
);

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_weight;
    logic [31:0] r_bias;

    // Write a coefficient
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read weight and bias every cycle
    always_ff @(posedge i_clk) begin
        r_weight <= r_mem[i_raddr_w];
        r_bias   <= r_mem[i_raddr_b];
    end

    assign o_weight = r_weight;
    assign o_bias   = r_bias;

endmodule

### rtl/lpe_mul.sv
// Multiply stage and Q32.32 to Q33.24 rounding stage.
module lpe_mul import lpe_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_ctl         i_ctl,
    input  logic [31:0]  i_weight,
    input  logic [31:0]  i_bias,
    input  logic [31:0]  i_sample,
    output t_ctl         o_ctl,
    output logic [31:0]  o_beta,
    output logic [39:0]  o_bias_q24,
    output logic [56:0]  o_prod_q24
);

    t_ctl               r_p_ctl;
    logic [31:0]        r_p_beta;
    logic [31:0]        r_p_bias;
    logic signed [63:0] r_p_prod;
    t_ctl               r_r_ctl;
    logic [31:0]        r_r_beta;
    logic [39:0]        r_r_bias;
    logic [56:0]        r_r_prod;

    logic signed [63:0] n_prod;
    logic signed [64:0] rnd_sum;

    // Full signed product of weight and descriptor
    assign n_prod = $signed(i_weight) * $signed(i_sample);

    // Add half an LSB, then floor by dropping eight bits
    assign rnd_sum = $signed({r_p_prod[63], r_p_prod}) + 65'sd128;

    // Advance control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_ctl <= '0;
            r_r_ctl <= '0;
        end else begin
            r_p_ctl <= i_ctl;
            r_r_ctl <= r_p_ctl;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_p_beta <= i_weight;
        r_p_bias <= i_bias;
        r_p_prod <= n_prod;
        r_r_beta <= r_p_beta;
        r_r_bias <= {r_p_bias, 8'd0};
        r_r_prod <= rnd_sum[64:8];
    end

    assign o_ctl      = r_r_ctl;
    assign o_beta     = r_r_beta;
    assign o_bias_q24 = r_r_bias;
    assign o_prod_q24 = r_r_prod;

endmodule

### rtl/lpe_acc.sv
// Saturating atom accumulator and running energy total.
module lpe_acc import lpe_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_ctl        i_ctl,
    input  logic [31:0] i_beta,
    input  logic [39:0] i_bias_q24,
    input  logic [56:0] i_prod_q24,
    output logic        o_push,
    output t_result     o_result
);

    localparam logic signed [57:0] Q_MAX = 58'sh0007FFFFFFFFFFF;
    localparam logic signed [57:0] Q_MIN = -Q_MAX - 58'sd1;

    logic [47:0] r_acc;
    t_ctl        r_b_ctl;
    logic [31:0] r_b_beta;
    logic [47:0] r_b_atom;
    logic        r_b_sat;
    logic [47:0] r_total;
    logic        r_flag;

    logic [47:0] n_acc;
    logic [47:0] n_atom;
    logic        n_sat;
    logic [47:0] n_total;
    logic        n_flag;
    logic [48:0] sat_bias;
    logic [48:0] sat_prod;
    logic [48:0] sat_tot;
    logic [47:0] acc_mid;

    // Clamp to the signed 48-bit range; top bit reports a clamp
    function automatic logic [48:0] sat48(input logic signed [57:0] s);
        logic [48:0] r;
        if (s > Q_MAX) begin
            r = {1'b1, Q_MAX[47:0]};
        end else if (s < Q_MIN) begin
            r = {1'b1, Q_MIN[47:0]};
        end else begin
            r = {1'b0, s[47:0]};
        end
        return r;
    endfunction

    // Add bias on descriptor zero, then the rounded product
    always_comb begin
        sat_bias = sat48($signed({{10{r_acc[47]}}, r_acc})
                       + $signed({{18{i_bias_q24[39]}}, i_bias_q24}));
        acc_mid  = i_ctl.first ? sat_bias[47:0] : r_acc;
        sat_prod = sat48($signed({{10{acc_mid[47]}}, acc_mid})
                       + $signed({i_prod_q24[56], i_prod_q24}));
        n_acc  = r_acc;
        n_atom = '0;
        n_sat  = 1'b0;
        if (i_ctl.clr) begin
            n_acc = '0;
        end else if (i_ctl.res && i_ctl.use_e) begin
            n_sat = (i_ctl.first & sat_bias[48]) | sat_prod[48];
            if (i_ctl.done) begin
                n_atom = sat_prod[47:0];
                n_acc  = '0;
            end else begin
                n_acc = sat_prod[47:0];
            end
        end
    end

    // Fold finished atoms into the total
    always_comb begin
        sat_tot = sat48($signed({{10{r_total[47]}}, r_total})
                      + $signed({{10{r_b_atom[47]}}, r_b_atom}));
        n_total = r_total;
        n_flag  = r_flag;
        if (r_b_ctl.clr) begin
            n_total = '0;
            n_flag  = 1'b0;
        end else if (r_b_ctl.res) begin
            n_flag = r_flag | r_b_sat;
            if (r_b_ctl.use_e && r_b_ctl.done) begin
                n_total = sat_tot[47:0];
                n_flag  = r_flag | r_b_sat | sat_tot[48];
            end
        end
    end

    // Hold energy state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_b_ctl <= '0;
            r_total <= '0;
            r_flag  <= 1'b0;
        end else begin
            r_acc   <= n_acc;
            r_b_ctl <= i_ctl;
            r_total <= n_total;
            r_flag  <= n_flag;
        end
    end

    // Advance payload
    always_ff @(posedge i_clk) begin
        r_b_beta <= i_beta;
        r_b_atom <= n_atom;
        r_b_sat  <= n_sat;
    end

    assign o_push                = r_b_ctl.res;
    assign o_result.beta         = r_b_beta;
    assign o_result.atom_energy  = r_b_atom;
    assign o_result.total_energy = n_total;
    assign o_result.atom_done    = r_b_ctl.done;
    assign o_result.overflow     = n_flag;

endmodule

### rtl/lpe_out_fifo.sv
// Output queue that decouples the pipeline from the result receiver.
module lpe_out_fifo import lpe_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_data,
    input  logic    i_pop,
    output logic    o_valid,
    output t_result o_data
);

    t_result          r_mem [FIFO_DEPTH];
    logic [PTR_W:0]   r_wr;
    logic [PTR_W:0]   r_rd;

    // Store pushed results
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[PTR_W-1:0]] <= i_data;
        end
    end

    // Advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

    assign o_valid = (r_wr != r_rd);
    assign o_data  = r_mem[r_rd[PTR_W-1:0]];

endmodule

### rtl/linear_potential_energy_dot.sv
// Linear per-atom energy model: coefficient store, MAC pipeline and output queue.
//
// Usage:
//   Requests enter on i_valid/o_stall; results leave on o_valid/i_stall.
//   A load request writes one coefficient (slot 0 is the species bias).
//   A sample request returns one result: beta, and with energy enabled the
//   atom energy on the last descriptor plus the running total.
//   A clear request zeroes the total, the atom accumulator and the overflow
//   flag. Loads and clears give no result.
//   Configuration writes (descriptor count, energy enable) go through the i_cfg_*
//   port; the user must make them while no request is in flight (not enforced).
// Timing:
//   One request is accepted per clock while o_stall is low. Each sample goes
//   through memory read, multiply, round, accumulate and total, in order.
//   An eight-entry output queue with credit counting absorbs receiver stalls;
//   o_stall rises once eight results are in flight or waiting.
// Reset:
//   Synchronous reset empties the pipeline and queue, zeroes the energy state
//   and restores the default configuration. Coefficients are undefined until
//   loaded.
module linear_potential_energy_dot import lpe_pkg::*; #(
    parameter int MAX_SPECIES     = 8,
    parameter int MAX_DESCRIPTORS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [1:0]            i_op,
    input  logic [2:0]            i_species,
    input  logic [6:0]            i_slot,
    input  logic signed [31:0]    i_sample,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic signed [31:0]    o_beta,
    output logic signed [47:0]    o_atom_energy,
    output logic signed [47:0]    o_total_energy,
    output logic                  o_atom_done,
    output logic                  o_overflow
);

    localparam int SLOTS = MAX_DESCRIPTORS + 1;
    localparam int DEPTH = MAX_SPECIES * SLOTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NCAP  = (MAX_DESCRIPTORS < 127) ? MAX_DESCRIPTORS : 127;
    localparam logic [6:0] NCAP7 = NCAP[6:0];

    logic [6:0]       r_desc;
    logic             r_energy_en;
    t_ctl             r_s1_ctl;
    logic [31:0]      r_s1_sample;
    logic             r_s1_w_ok;
    logic             r_s1_b_ok;
    logic [CNT_W-1:0] r_credit;

    logic          accept;
    logic          is_sample;
    logic          species_ok;
    logic          load_ok;
    logic          weight_ok;
    logic [6:0]    n_eff;
    logic [AW-1:0] base_addr;
    logic [AW-1:0] slot_addr;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_w;
    logic [AW-1:0] raddr_b;
    logic          mem_we;
    logic [31:0]   rd_weight;
    logic [31:0]   rd_bias;
    logic [31:0]   weight;
    logic [31:0]   bias;
    t_ctl          n_s1_ctl;
    t_ctl          mul_ctl;
    logic [31:0]   mul_beta;
    logic [39:0]   mul_bias;
    logic [56:0]   mul_prod;
    logic          push;
    t_result       push_data;
    logic          pop;
    t_result       out_data;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_desc      <= DESC_RESET;
            r_energy_en <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_DESCRIPTORS_IN_USE: r_desc      <= i_cfg_wdata;
                REG_ENERGY_ENABLE:      r_energy_en <= i_cfg_wdata[0];
                default:                r_desc      <= r_desc;
            endcase
        end
    end

    // Clamp the descriptor count to 1..NCAP (MAX_DESCRIPTORS, at most 127)
    always_comb begin
        if (r_desc == 7'd0) begin
            n_eff = 7'd1;
        end else if (r_desc > NCAP7) begin
            n_eff = NCAP7;
        end else begin
            n_eff = r_desc;
        end
    end

    assign accept    = i_valid && !o_stall;
    assign is_sample = (i_op == OP_SAMPLE);

    // Coefficient addressing; out-of-range species or slots read as zero
    assign species_ok = int'(i_species) < MAX_SPECIES;
    assign load_ok    = species_ok && (int'(i_slot) < SLOTS);
    assign weight_ok  = species_ok && (int'(i_slot) < MAX_DESCRIPTORS);
    assign base_addr  = species_ok ? AW'(int'(i_species) * SLOTS) : '0;
    assign slot_addr  = AW'(i_slot);
    assign waddr      = load_ok ? (base_addr + slot_addr) : '0;
    assign raddr_w    = weight_ok ? (base_addr + slot_addr + AW'(1)) : '0;
    assign raddr_b    = base_addr;
    assign mem_we     = accept && (i_op == OP_LOAD) && load_ok;

    // Decode the request into pipeline control
    always_comb begin
        n_s1_ctl       = '0;
        n_s1_ctl.res   = accept && is_sample;
        n_s1_ctl.clr   = accept && (i_op == OP_CLEAR);
        n_s1_ctl.use_e = r_energy_en && (i_slot < n_eff);
        n_s1_ctl.first = (i_slot == 7'd0);
        n_s1_ctl.done  = (i_slot == (n_eff - 7'd1));
    end

    // Hold the request beside the memory read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_ctl <= '0;
        end else begin
            r_s1_ctl <= n_s1_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_sample <= i_sample;
        r_s1_w_ok   <= weight_ok;
        r_s1_b_ok   <= species_ok;
    end

    lpe_coef_mem #(
        .DEPTH (DEPTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (waddr),
        .i_wdata   (i_sample),
        .i_raddr_w (raddr_w),
        .i_raddr_b (raddr_b),
        .o_weight  (rd_weight),
        .o_bias    (rd_bias)
    );

    assign weight = r_s1_w_ok ? rd_weight : '0;
    assign bias   = r_s1_b_ok ? rd_bias : '0;

    lpe_mul u_mul (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (r_s1_ctl),
        .i_weight   (weight),
        .i_bias     (bias),
        .i_sample   (r_s1_sample),
        .o_ctl      (mul_ctl),
        .o_beta     (mul_beta),
        .o_bias_q24 (mul_bias),
        .o_prod_q24 (mul_prod)
    );

    lpe_acc u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (mul_ctl),
        .i_beta     (mul_beta),
        .i_bias_q24 (mul_bias),
        .i_prod_q24 (mul_prod),
        .o_push     (push),
        .o_result   (push_data)
    );

    lpe_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_data),
        .i_pop   (pop),
        .o_valid (o_valid),
        .o_data  (out_data)
    );

    assign pop = o_valid && !i_stall;

    // Count results in flight or queued; stall when the queue could fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_credit <= '0;
        end else begin
            r_credit <= r_credit + CNT_W'(n_s1_ctl.res) - CNT_W'(pop);
        end
    end

    assign o_stall = (r_credit == CNT_W'(FIFO_DEPTH));

    assign o_beta         = out_data.beta;
    assign o_atom_energy  = out_data.atom_energy;
    assign o_total_energy = out_data.total_energy;
    assign o_atom_done    = out_data.atom_done;
    assign o_overflow     = out_data.overflow;

endmodule

### rtl/lpe_checker.sv
// Port-level checks for the linear energy block, bound to the top level.
module lpe_checker import lpe_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic [1:0]         i_op,
    input logic               o_stall,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_beta,
    input logic signed [47:0] o_atom_energy,
    input logic signed [47:0] o_total_energy,
    input logic               o_atom_done
);

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Atom energy is reported only on the last descriptor
    a_energy_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_atom_done |-> o_atom_energy == 48'sd0)
        else $error("atom energy without atom done");

    // A stalled result stays valid with beta and total unchanged
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_beta) && $stable(o_total_energy))
        else $error("stalled result changed");

    // Stall only rises after a sample request is taken
    a_stall_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_stall && !(i_valid && i_op == OP_SAMPLE) |=> !o_stall)
        else $error("input stall rose without a new sample request");

endmodule

bind linear_potential_energy_dot lpe_checker u_lpe_checker (.*);
